/* src/tbt_pkg.sv */
// shared types and constants for the triangle tangent/bitangent block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tbt_pkg;

  localparam int POS_W  = 32;
  localparam int TEX_W  = 16;
  localparam int EDGE_W = POS_W + 1;
  localparam int DLT_W  = TEX_W + 1;
  localparam int PROD_W = EDGE_W + DLT_W;
  localparam int DET_W  = 2 * DLT_W + 1;
  localparam int NUM_W  = 64;
  localparam int UV_SHIFT = 12;
  localparam int REM_W  = 63;
  localparam int QUO_W  = POS_W + 1;
  localparam int DIV_W  = DET_W + QUO_W;
  localparam int STEP_W = 6;
  localparam int COMP_W = 3;
  localparam logic [COMP_W-1:0] LAST_COMP = COMP_W'(5);
  localparam logic [1:0] THIRD_CORNER = 2'd2;

  typedef struct packed {
    logic              cap_corner;
    logic              corner;
    logic              cap_third;
    logic              det0;
    logic              det1;
    logic              det_sub;
    logic              chk;
    logic              zero;
    logic              num0;
    logic              num1;
    logic              num2;
    logic              prep;
    logic              div_step;
    logic              store;
    logic [COMP_W-1:0] comp;
    logic              set_valid;
  } tbt_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic out_busy;
  } tbt_sts_t;

endpackage
`default_nettype wire

/* src/tbt_ctrl.sv */
// sequencer for corner capture, determinant, numerators and division
// depends on tbt_pkg
`timescale 1ns / 1ps
`default_nettype none
module tbt_ctrl
  import tbt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  tbt_sts_t  sts,
  output tbt_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DET0 = 10'b0000000010,
    S_DET1 = 10'b0000000100,
    S_DETC = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_NUM0 = 10'b0000100000,
    S_NUM1 = 10'b0001000000,
    S_NUM2 = 10'b0010000000,
    S_PREP = 10'b0100000000,
    S_DIV  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]        count_r, count_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              store_r, store_nxt;
  logic              in_xfer;

  assign in_stall = (state_r != S_IDLE) || store_r ||
                    ((count_r >= THIRD_CORNER) && sts.out_busy);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    store_nxt = 1'b0;
    cmd       = '0;
    cmd.comp  = comp_r;
    cmd.corner = count_r[0];
    if (store_r) begin
      cmd.store = 1'b1;
      if (comp_r == LAST_COMP) begin
        cmd.set_valid = 1'b1;
      end else begin
        comp_nxt  = comp_r + COMP_W'(1);
        state_nxt = S_NUM0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (count_r < THIRD_CORNER) begin
              cmd.cap_corner = 1'b1;
              count_nxt = count_r + 2'd1;
            end else begin
              cmd.cap_third = 1'b1;
              count_nxt = 2'd0;
              state_nxt = S_DET0;
            end
          end
        end
        S_DET0: begin
          cmd.det0  = 1'b1;
          state_nxt = S_DET1;
        end
        S_DET1: begin
          cmd.det1  = 1'b1;
          state_nxt = S_DETC;
        end
        S_DETC: begin
          cmd.det_sub = 1'b1;
          state_nxt   = S_CHK;
        end
        S_CHK: begin
          cmd.chk = 1'b1;
          if (sts.det_zero) begin
            cmd.zero      = 1'b1;
            cmd.set_valid = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            comp_nxt  = '0;
            state_nxt = S_NUM0;
          end
        end
        S_NUM0: begin
          cmd.num0  = 1'b1;
          state_nxt = S_NUM1;
        end
        S_NUM1: begin
          cmd.num1  = 1'b1;
          state_nxt = S_NUM2;
        end
        S_NUM2: begin
          cmd.num2  = 1'b1;
          state_nxt = S_PREP;
        end
        S_PREP: begin
          cmd.prep  = 1'b1;
          step_nxt  = STEP_W'(QUO_W - 1);
          state_nxt = S_DIV;
        end
        S_DIV: begin
          cmd.div_step = 1'b1;
          step_nxt = step_r - STEP_W'(1);
          if (step_r == '0) begin
            store_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      comp_r  <= '0;
      step_r  <= '0;
      store_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      comp_r  <= comp_nxt;
      step_r  <= step_nxt;
      store_r <= store_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && count_r == THIRD_CORNER) |=> (state_r == S_DET0))
    else $error("third corner did not start the sequence");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == '0) |=> store_r)
    else $error("division did not end in a store");
  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    store_r |-> (comp_r <= LAST_COMP))
    else $error("component index out of range");
`endif

endmodule
`default_nettype wire

/* src/tbt_dp.sv */
// datapath: held corners, deltas, shared multiplier, restoring divider, result registers
// depends on tbt_pkg
`timescale 1ns / 1ps
`default_nettype none
module tbt_dp
  import tbt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic signed [POS_W-1:0] in_pos_x,
  input  wire logic signed [POS_W-1:0] in_pos_y,
  input  wire logic signed [POS_W-1:0] in_pos_z,
  input  wire logic signed [TEX_W-1:0] in_tex_u,
  input  wire logic signed [TEX_W-1:0] in_tex_v,
  input  tbt_cmd_t                     cmd,
  output tbt_sts_t                     sts,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic signed [POS_W-1:0]      out_tangent_x,
  output logic signed [POS_W-1:0]      out_tangent_y,
  output logic signed [POS_W-1:0]      out_tangent_z,
  output logic signed [POS_W-1:0]      out_bitangent_x,
  output logic signed [POS_W-1:0]      out_bitangent_y,
  output logic signed [POS_W-1:0]      out_bitangent_z,
  output logic                         out_degenerate
);

  logic signed [POS_W-1:0]  hpos_r [6];
  logic signed [TEX_W-1:0]  htex_r [4];
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [DLT_W-1:0]  d1u_r, d1v_r, d2u_r, d2v_r;
  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic signed [DET_W-1:0]  det_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [DET_W-1:0]         dabs_r;
  logic [REM_W-1:0]         rem_r;
  logic [DIV_W-1:0]         div_r;
  logic [QUO_W-1:0]         q_r;
  logic                     neg_r, ovf_r;
  logic signed [POS_W-1:0]  res_r [6];
  logic                     deg_r;
  logic                     valid_r;

  logic signed [POS_W-1:0]  pin [3];
  logic [1:0]               axis;
  logic                     second_half;
  logic signed [EDGE_W-1:0] mul_a;
  logic signed [DLT_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W:0]   num_diff;
  logic [NUM_W-1:0]         num_abs;
  logic [DIV_W-1:0]         rem_ext;
  logic [DIV_W-1:0]         rem_sub;
  logic [POS_W-1:0]         res;

  assign pin[0] = in_pos_x;
  assign pin[1] = in_pos_y;
  assign pin[2] = in_pos_z;

  assign second_half = (cmd.comp > COMP_W'(2));
  assign axis = second_half ? 2'(cmd.comp - COMP_W'(3)) : cmd.comp[1:0];

  always_comb begin
    mul_a = e1_r[axis];
    mul_b = d2v_r;
    if (cmd.det0) begin
      mul_a = EDGE_W'(d1u_r);
      mul_b = d2v_r;
    end else if (cmd.det1) begin
      mul_a = EDGE_W'(d1v_r);
      mul_b = d2u_r;
    end else if (cmd.num1) begin
      mul_a = second_half ? e1_r[axis] : e2_r[axis];
      mul_b = second_half ? d2u_r : d1v_r;
    end else begin
      mul_a = second_half ? e2_r[axis] : e1_r[axis];
      mul_b = second_half ? d1u_r : d2v_r;
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign num_diff = (PROD_W+1)'(acc_r) - (PROD_W+1)'(prod_r);
  assign num_abs  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign rem_ext  = DIV_W'(rem_r);
  assign rem_sub  = rem_ext - div_r;

  always_comb begin
    if (ovf_r) begin
      res = neg_r ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (!neg_r) begin
      res = (q_r[QUO_W-1] || q_r[QUO_W-2]) ? 32'h7fff_ffff : q_r[POS_W-1:0];
    end else begin
      res = (q_r > QUO_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (-q_r[POS_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_corner) begin
      for (int i = 0; i < 3; i++) begin
        hpos_r[3*cmd.corner + i] <= pin[i];
      end
      htex_r[2*cmd.corner]     <= in_tex_u;
      htex_r[2*cmd.corner + 1] <= in_tex_v;
    end
    if (cmd.cap_third) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EDGE_W'(hpos_r[3+i]) - EDGE_W'(hpos_r[i]);
        e2_r[i] <= EDGE_W'(pin[i]) - EDGE_W'(hpos_r[i]);
      end
      d1u_r <= DLT_W'(htex_r[2]) - DLT_W'(htex_r[0]);
      d1v_r <= DLT_W'(htex_r[3]) - DLT_W'(htex_r[1]);
      d2u_r <= DLT_W'(in_tex_u) - DLT_W'(htex_r[0]);
      d2v_r <= DLT_W'(in_tex_v) - DLT_W'(htex_r[1]);
    end
    if (cmd.det0 || cmd.det1 || cmd.num0 || cmd.num1) begin
      prod_r <= mul_p;
    end
    if (cmd.det1 || cmd.num1) begin
      acc_r <= prod_r;
    end
    if (cmd.det_sub) begin
      det_r <= DET_W'(num_diff);
    end
    if (cmd.chk) begin
      dabs_r <= det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
      deg_r  <= sts.det_zero;
    end
    if (cmd.num2) begin
      num_r <= NUM_W'(num_diff) <<< UV_SHIFT;
    end
    if (cmd.prep) begin
      rem_r <= REM_W'(num_abs);
      neg_r <= num_r[NUM_W-1] ^ det_r[DET_W-1];
      ovf_r <= ({5'd0, num_abs} >= ({dabs_r, {QUO_W{1'b0}}}));
      div_r <= {1'b0, dabs_r, {(QUO_W-1){1'b0}}};
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (!ovf_r && rem_ext >= div_r) begin
        rem_r <= REM_W'(rem_sub);
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
      div_r <= div_r >> 1;
    end
    if (cmd.zero) begin
      for (int i = 0; i < 6; i++) begin
        res_r[i] <= '0;
      end
    end
    if (cmd.store) begin
      res_r[cmd.comp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.set_valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  assign sts.det_zero = (det_r == '0);
  assign sts.out_busy = valid_r;

  assign out_valid       = valid_r;
  assign out_tangent_x   = res_r[0];
  assign out_tangent_y   = res_r[1];
  assign out_tangent_z   = res_r[2];
  assign out_bitangent_x = res_r[3];
  assign out_bitangent_y = res_r[4];
  assign out_bitangent_z = res_r[5];
  assign out_degenerate  = deg_r;

endmodule
`default_nettype wire

/* src/triangle_tangent_bitangent.sv */
// top level: per-triangle tangent and bitangent from texture coordinates
// depends on tbt_pkg, tbt_ctrl, tbt_dp
//
// usage:
//   input channel (in_valid / in_stall) carries one vertex per transfer:
//   position in signed Q16.16 and texture coordinate in signed Q4.12
//   the first two vertices of each triangle are stored as they are taken
//   the third vertex starts the computation; one result follows on the
//   output channel (out_valid / out_stall) once the sequence has ended
//   no result is produced for the first two vertices
//   after the third vertex the input stalls while the block runs a
//   determinant (det0, det1, subtract, check) and then, for each of the
//   six vector components, one shared multiplier and a one-bit-per-cycle
//   divider, so no new vertex is taken before the triangle is finished
//   a zero uv determinant gives zero vectors with degenerate set once the
//   determinant is checked; the next vertex can be taken in the cycle after
//   the result register holds while out_stall is high; stored vertices are
//   still taken, a third vertex waits until the result is transferred
//   synchronous active-low reset clears the corner count and output valid
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_bitangent
  import tbt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [POS_W-1:0] in_pos_x,
  input  wire logic signed [POS_W-1:0] in_pos_y,
  input  wire logic signed [POS_W-1:0] in_pos_z,
  input  wire logic signed [TEX_W-1:0] in_tex_u,
  input  wire logic signed [TEX_W-1:0] in_tex_v,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [POS_W-1:0]      out_tangent_x,
  output logic signed [POS_W-1:0]      out_tangent_y,
  output logic signed [POS_W-1:0]      out_tangent_z,
  output logic signed [POS_W-1:0]      out_bitangent_x,
  output logic signed [POS_W-1:0]      out_bitangent_y,
  output logic signed [POS_W-1:0]      out_bitangent_z,
  output logic                         out_degenerate
);

  tbt_cmd_t cmd;
  tbt_sts_t sts;

  tbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_tex_u        (in_tex_u),
    .in_tex_v        (in_tex_v),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_tangent_x   (out_tangent_x),
    .out_tangent_y   (out_tangent_y),
    .out_tangent_z   (out_tangent_z),
    .out_bitangent_x (out_bitangent_x),
    .out_bitangent_y (out_bitangent_y),
    .out_bitangent_z (out_bitangent_z),
    .out_degenerate  (out_degenerate)
  );

endmodule
`default_nettype wire
